// ===== rtl/core/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescaper.
// No dependencies.

package jsu_pkg;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;

    localparam logic [15:0] POS_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_CHAR  = 2'd0,
        ST_DONE  = 2'd1,
        ST_ERROR = 2'd2
    } status_t;

    // One classified input byte.
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] esc_char;
        logic [3:0] hex_val;
        logic       is_zero;
        logic       is_quote;
        logic       is_bslash;
        logic       is_u;
        logic       is_hex;
    } class_t;

endpackage

// ===== rtl/core/jsu_front.sv =====
// Front stage: registers each input byte with its classification.
// Depends on jsu_pkg.

module jsu_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     in_byte,
    output logic           cls_valid,
    input  logic           cls_ready,
    output jsu_pkg::class_t cls
);

    logic            valid_reg;
    logic            valid_next;
    jsu_pkg::class_t cls_reg;
    jsu_pkg::class_t cls_next;

    always_comb
    begin
        cls_next           = '0;
        cls_next.data      = in_byte;
        cls_next.is_zero   = (in_byte == jsu_pkg::CH_NUL);
        cls_next.is_quote  = (in_byte == jsu_pkg::CH_QUOTE);
        cls_next.is_bslash = (in_byte == jsu_pkg::CH_BSLASH);
        cls_next.is_u      = (in_byte == jsu_pkg::CH_LC_U);

        unique case (in_byte)
            jsu_pkg::CH_LC_B: cls_next.esc_char = jsu_pkg::CH_BS;
            jsu_pkg::CH_LC_F: cls_next.esc_char = jsu_pkg::CH_FF;
            jsu_pkg::CH_LC_N: cls_next.esc_char = jsu_pkg::CH_LF;
            jsu_pkg::CH_LC_R: cls_next.esc_char = jsu_pkg::CH_CR;
            jsu_pkg::CH_LC_T: cls_next.esc_char = jsu_pkg::CH_TAB;
            default:          cls_next.esc_char = in_byte;
        endcase

        priority if (in_byte >= 8'h30 && in_byte <= 8'h39)
        begin
            cls_next.is_hex  = 1'b1;
            cls_next.hex_val = 4'(in_byte - 8'h30);
        end
        else if (in_byte >= 8'h61 && in_byte <= 8'h66)
        begin
            cls_next.is_hex  = 1'b1;
            cls_next.hex_val = 4'(in_byte - 8'h57);
        end
        else if (in_byte >= 8'h41 && in_byte <= 8'h46)
        begin
            cls_next.is_hex  = 1'b1;
            cls_next.hex_val = 4'(in_byte - 8'h37);
        end
        else
        begin
            cls_next.is_hex  = 1'b0;
            cls_next.hex_val = 4'd0;
        end
    end

    assign in_ready   = !valid_reg || cls_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cls_reg <= cls_next;
        end
    end

    assign cls_valid = valid_reg;
    assign cls       = cls_reg;

endmodule

// ===== rtl/core/jsu_queue.sv =====
// Small FIFO of classified beats between front and back stages.
// Depends on jsu_pkg.

module jsu_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  jsu_pkg::class_t wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output jsu_pkg::class_t rd_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    jsu_pkg::class_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/jsu_back.sv =====
// Back stage: string/escape/hex state machine and output register.
// Depends on jsu_pkg.

module jsu_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cls_valid,
    output logic            cls_ready,
    input  jsu_pkg::class_t cls,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [1:0]      status,
    output logic [7:0]      char_out,
    output logic [15:0]     position
);

    typedef enum logic [3:0] {
        M_IDLE   = 4'b0001,
        M_STRING = 4'b0010,
        M_ESCAPE = 4'b0100,
        M_HEX    = 4'b1000
    } mode_t;

    mode_t       mode_reg;
    mode_t       mode_next;
    logic [1:0]  hex_cnt_reg;
    logic [1:0]  hex_cnt_next;
    logic [15:0] hex_acc_reg;
    logic [15:0] hex_acc_next;
    logic [15:0] offset_reg;
    logic [15:0] offset_next;
    logic [15:0] offset_inc;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;
    logic [7:0]  char_reg;
    logic [7:0]  char_next;
    logic [15:0] pos_reg;
    logic [15:0] pos_next;

    logic        take;
    logic        emit;
    logic [15:0] acc_shift;

    assign cls_ready  = !out_valid_reg || out_ready;
    assign take       = cls_valid && cls_ready;
    assign offset_inc = (offset_reg == jsu_pkg::POS_MAX) ? offset_reg : offset_reg + 16'd1;
    assign acc_shift  = {hex_acc_reg[11:0], cls.hex_val};

    always_comb
    begin
        mode_next    = mode_reg;
        hex_cnt_next = hex_cnt_reg;
        hex_acc_next = hex_acc_reg;
        offset_next  = offset_reg;
        emit         = 1'b0;
        status_next  = jsu_pkg::ST_CHAR;
        char_next    = 8'd0;

        if (mode_reg == M_IDLE)
        begin
            offset_next = 16'd0;
            if (cls.is_quote)
            begin
                mode_next = M_STRING;
            end
            else
            begin
                emit        = 1'b1;
                status_next = jsu_pkg::ST_ERROR;
            end
        end
        else
        begin
            offset_next = offset_inc;
            if (cls.is_zero)
            begin
                emit        = 1'b1;
                status_next = jsu_pkg::ST_ERROR;
                mode_next   = M_IDLE;
            end
            else
            begin
                unique case (mode_reg)
                    M_STRING:
                    begin
                        priority if (cls.is_quote)
                        begin
                            emit        = 1'b1;
                            status_next = jsu_pkg::ST_DONE;
                            mode_next   = M_IDLE;
                        end
                        else if (cls.is_bslash)
                        begin
                            mode_next = M_ESCAPE;
                        end
                        else
                        begin
                            emit      = 1'b1;
                            char_next = cls.data;
                        end
                    end
                    M_ESCAPE:
                    begin
                        if (cls.is_u)
                        begin
                            mode_next    = M_HEX;
                            hex_cnt_next = 2'd0;
                            hex_acc_next = 16'd0;
                        end
                        else
                        begin
                            emit      = 1'b1;
                            char_next = cls.esc_char;
                            mode_next = M_STRING;
                        end
                    end
                    M_HEX:
                    begin
                        if (!cls.is_hex)
                        begin
                            emit        = 1'b1;
                            status_next = jsu_pkg::ST_ERROR;
                            mode_next   = M_IDLE;
                        end
                        else
                        begin
                            hex_acc_next = acc_shift;
                            hex_cnt_next = hex_cnt_reg + 2'd1;
                            if (hex_cnt_reg == 2'd3)
                            begin
                                emit      = 1'b1;
                                mode_next = M_STRING;
                                char_next = (acc_shift[15:7] == '0) ? acc_shift[7:0]
                                                                    : jsu_pkg::CH_QMARK;
                            end
                        end
                    end
                    default:
                    begin
                        mode_next = M_IDLE;
                    end
                endcase
            end
        end
        pos_next = offset_next;
    end

    always_comb
    begin
        if (take)
        begin
            out_valid_next = emit;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_IDLE;
            hex_cnt_reg   <= 2'd0;
            hex_acc_reg   <= 16'd0;
            offset_reg    <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                mode_reg    <= mode_next;
                hex_cnt_reg <= hex_cnt_next;
                hex_acc_reg <= hex_acc_next;
                offset_reg  <= offset_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            status_reg <= status_next;
            char_reg   <= char_next;
            pos_reg    <= pos_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign char_out  = char_reg;
    assign position  = pos_reg;

endmodule

// ===== rtl/core/json_string_unescaper_core.sv =====
// Top level of the JSON string unescaper: front classifier, beat queue, back decoder.
// Depends on jsu_pkg, jsu_front, jsu_queue, jsu_back.
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid, in_ready, in_byte[7:0]           | in
//  out     | out_valid, out_ready, status[1:0],         | out
//          | char_out[7:0], position[15:0]              |
//
// One byte per cycle sustained while out_ready stays high; a byte that yields a result shows it
// after passing the classifier register, the queue and the output register.
// The back decoder takes one queued beat per cycle whenever its output register is
// empty or being drained; the queue absorbs front/back stalls independently.
// Reset clears all control state; the decoder starts idle awaiting an opening quote.

module json_string_unescaper_core
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  char_out,
    output logic [15:0] position
);

    logic            f_valid;
    logic            f_ready;
    jsu_pkg::class_t f_cls;
    logic            q_valid;
    logic            q_ready;
    jsu_pkg::class_t q_cls;

    jsu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .cls_valid (f_valid),
        .cls_ready (f_ready),
        .cls       (f_cls)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_cls),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_cls)
    );

    jsu_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (q_valid),
        .cls_ready (q_ready),
        .cls       (q_cls),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .char_out  (char_out),
        .position  (position)
    );

endmodule
